/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of this project.
// Needs nothing else; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that prop holds at every rising edge of clk_i while reset is released.
`define DEQ_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that cond is never true at a rising edge of clk_i while reset is released.
`define DEQ_ASSERT_NEVER(lbl, clk_i, rst_ni, cond, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define DEQ_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`define DEQ_ASSERT_NEVER(lbl, clk_i, rst_ni, cond, msg)
`endif
`endif

/* hw/rtl/deq_pkg.sv */
// Shared types and constants of the double-ended queue.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package deq_pkg;

	localparam int DEPTH_DEF      = 256;
	localparam int VALUE_BITS_DEF = 32;
	localparam int OP_BITS        = 3;
	localparam int STATUS_BITS    = 2;

	typedef enum logic [OP_BITS-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_REMOVE     = 3'd4
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

endpackage

`default_nettype wire

/* hw/rtl/deq_if.sv */
// Valid/ready channel interfaces of the double-ended queue (request and response).
// Depends on deq_pkg.
`default_nettype none

interface deq_in_if #(
	parameter int VALUE_BITS = deq_pkg::VALUE_BITS_DEF
) ();
	logic                              valid;
	logic                              ready;
	logic [deq_pkg::OP_BITS-1:0]       operation;
	logic signed [VALUE_BITS-1:0]      value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

interface deq_out_if #(
	parameter int VALUE_BITS = deq_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = $clog2(deq_pkg::DEPTH_DEF + 1)
) ();
	logic                              valid;
	logic                              ready;
	logic signed [VALUE_BITS-1:0]      popped_value;
	logic [deq_pkg::STATUS_BITS-1:0]   status;
	logic [COUNT_BITS-1:0]             entry_count;

	modport source (output valid, output popped_value, output status, output entry_count,
		input ready);
	modport sink (input valid, input popped_value, input status, input entry_count,
		output ready);
endinterface

`default_nettype wire

/* hw/rtl/double_ended_queue.sv */
// Bounded double-ended queue over one synchronous single-read-port memory.
// Depends on deq_pkg, deq_if.sv (deq_in_if, deq_out_if) and assert_macros.svh.
//
// The queue holds up to DEPTH signed values in a circular memory addressed by a
// head slot (front entry) and a tail slot (next free slot at the back). Each
// request item carries an operation and a value and gets exactly one response
// item: the popped value (zero unless a pop succeeded), a status (ok, empty,
// full, not found) and the entry count after the operation. A push into a full
// queue is dropped and flagged; codes 5 to 7 do nothing and answer ok.
// From accepting a request until the block takes the next one: a push, a failed
// or ignored operation finishes at once; a pop waits in S_POP for the registered
// read data of the memory; a remove walks the memory's single read port one
// entry per cycle from the front until the match (S_SCAN), then each later entry
// is read and written back one slot forward, one per cycle (S_SHIFT). The
// response register is separate from the request side, so a request is accepted
// while the previous response still waits downstream; a finished response that
// cannot yet go out is parked until it can. The memory content needs no reset:
// only slots written by a push are ever read.
`default_nettype none

`include "assert_macros.svh"

module double_ended_queue #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = deq_pkg::VALUE_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	deq_in_if.sink     req,
	deq_out_if.source  rsp
);

	localparam int IDX_W   = $clog2(DEPTH);
	localparam int COUNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0]   LAST_SLOT  = IDX_W'(DEPTH - 1);
	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_POP   = 5'b00010,
		S_SCAN  = 5'b00100,
		S_SHIFT = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	// Circular slot arithmetic; DEPTH need not be a power of two.
	function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] s);
		return (s == '0) ? LAST_SLOT : s - 1'b1;
	endfunction

	// Entry memory: one write and one registered read per cycle.
	logic [VALUE_BITS-1:0] mem [DEPTH];
	logic [VALUE_BITS-1:0] rd_data_q;

	// Queue state and sequencer registers.
	state_t                state_q, state_nxt;
	logic [IDX_W-1:0]      head_q, head_nxt;
	logic [IDX_W-1:0]      tail_q, tail_nxt;
	logic [COUNT_W-1:0]    count_q, count_nxt;
	logic [COUNT_W-1:0]    idx_q, idx_nxt;        // logical index of the next scan read
	logic [IDX_W-1:0]      rd_slot_q, rd_slot_nxt;
	logic [IDX_W-1:0]      cmp_slot_q;            // slot whose data sits in rd_data_q
	logic [IDX_W-1:0]      wr_slot_q, wr_slot_nxt;
	logic [VALUE_BITS-1:0] val_q;

	// Memory port controls.
	logic                  wr_en, rd_en;
	logic [IDX_W-1:0]      wr_addr, rd_addr;
	logic [VALUE_BITS-1:0] wr_data;

	// Finishing result of the current item.
	logic                  fin;
	logic [VALUE_BITS-1:0] fin_value;
	deq_pkg::status_t      fin_status;

	// Parked result and response register.
	logic [VALUE_BITS-1:0] res_value_q;
	deq_pkg::status_t      res_status_q;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] out_value_q;
	deq_pkg::status_t      out_status_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic                  out_free;

	// A request is taken only when no earlier item is still at work.
	assign req.ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;

	always_comb begin
		state_nxt   = state_q;
		head_nxt    = head_q;
		tail_nxt    = tail_q;
		count_nxt   = count_q;
		idx_nxt     = idx_q;
		rd_slot_nxt = rd_slot_q;
		wr_slot_nxt = wr_slot_q;
		wr_en       = 1'b0;
		wr_addr     = tail_q;
		wr_data     = req.value;
		rd_en       = 1'b0;
		rd_addr     = rd_slot_q;
		fin         = 1'b0;
		fin_value   = '0;
		fin_status  = deq_pkg::ST_OK;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					unique case (req.operation)
						deq_pkg::OP_PUSH_BACK: begin
							fin = 1'b1;
							if (count_q == FULL_COUNT) begin
								fin_status = deq_pkg::ST_FULL;
							end else begin
								// Write at the tail, advance it.
								wr_en     = 1'b1;
								wr_addr   = tail_q;
								tail_nxt  = slot_inc(tail_q);
								count_nxt = count_q + 1'b1;
							end
						end
						deq_pkg::OP_PUSH_FRONT: begin
							fin = 1'b1;
							if (count_q == FULL_COUNT) begin
								fin_status = deq_pkg::ST_FULL;
							end else begin
								// Step the head back, write there.
								wr_en     = 1'b1;
								wr_addr   = slot_dec(head_q);
								head_nxt  = slot_dec(head_q);
								count_nxt = count_q + 1'b1;
							end
						end
						deq_pkg::OP_POP_BACK: begin
							if (count_q == '0) begin
								fin        = 1'b1;
								fin_status = deq_pkg::ST_EMPTY;
							end else begin
								rd_en     = 1'b1;
								rd_addr   = slot_dec(tail_q);
								tail_nxt  = slot_dec(tail_q);
								count_nxt = count_q - 1'b1;
								state_nxt = S_POP;
							end
						end
						deq_pkg::OP_POP_FRONT: begin
							if (count_q == '0) begin
								fin        = 1'b1;
								fin_status = deq_pkg::ST_EMPTY;
							end else begin
								rd_en     = 1'b1;
								rd_addr   = head_q;
								head_nxt  = slot_inc(head_q);
								count_nxt = count_q - 1'b1;
								state_nxt = S_POP;
							end
						end
						deq_pkg::OP_REMOVE: begin
							if (count_q == '0) begin
								fin        = 1'b1;
								fin_status = deq_pkg::ST_NOT_FOUND;
							end else begin
								// Start the walk at the front entry.
								rd_en       = 1'b1;
								rd_addr     = head_q;
								rd_slot_nxt = slot_inc(head_q);
								idx_nxt     = COUNT_W'(1);
								state_nxt   = S_SCAN;
							end
						end
						default: begin
							// Unused codes change nothing.
							fin = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				fin       = 1'b1;
				fin_value = rd_data_q;
			end
			S_SCAN: begin
				if (rd_data_q == val_q) begin
					if (idx_q == count_q) begin
						// Match on the last entry: just drop it.
						fin       = 1'b1;
						tail_nxt  = slot_dec(tail_q);
						count_nxt = count_q - 1'b1;
					end else begin
						// Read the successor now, write it over the match next cycle.
						rd_en       = 1'b1;
						rd_slot_nxt = slot_inc(rd_slot_q);
						idx_nxt     = idx_q + 1'b1;
						wr_slot_nxt = cmp_slot_q;
						state_nxt   = S_SHIFT;
					end
				end else if (idx_q == count_q) begin
					fin        = 1'b1;
					fin_status = deq_pkg::ST_NOT_FOUND;
				end else begin
					rd_en       = 1'b1;
					rd_slot_nxt = slot_inc(rd_slot_q);
					idx_nxt     = idx_q + 1'b1;
				end
			end
			S_SHIFT: begin
				// Move the entry just read one slot toward the front.
				wr_en       = 1'b1;
				wr_addr     = wr_slot_q;
				wr_data     = rd_data_q;
				wr_slot_nxt = slot_inc(wr_slot_q);
				if (idx_q == count_q) begin
					fin       = 1'b1;
					tail_nxt  = slot_dec(tail_q);
					count_nxt = count_q - 1'b1;
				end else begin
					rd_en       = 1'b1;
					rd_slot_nxt = slot_inc(rd_slot_q);
					idx_nxt     = idx_q + 1'b1;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase

		// Park the result if the response register is still occupied.
		if (fin) begin
			state_nxt = out_free ? S_IDLE : S_EMIT;
		end
	end

	// Memory: write first in program order, read data registered.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_nxt;
			head_q  <= head_nxt;
			tail_q  <= tail_nxt;
			count_q <= count_nxt;
		end
	end

	// Walk pointers, operand and parked result; no reset needed.
	always_ff @(posedge clk) begin
		idx_q     <= idx_nxt;
		rd_slot_q <= rd_slot_nxt;
		wr_slot_q <= wr_slot_nxt;
		if (rd_en) begin
			cmp_slot_q <= rd_addr;
		end
		if (req.valid && req.ready) begin
			val_q <= req.value;
		end
		if (fin && !out_free) begin
			res_value_q  <= fin_value;
			res_status_q <= fin_status;
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((fin || state_q == S_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin && out_free) begin
			out_value_q  <= fin_value;
			out_status_q <= fin_status;
			out_count_q  <= count_nxt;
		end else if (state_q == S_EMIT && out_free) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
			out_count_q  <= count_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.popped_value = out_value_q;
	assign rsp.status       = out_status_q;
	assign rsp.entry_count  = out_count_q;

	// Checks.
	`DEQ_ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > FULL_COUNT, "entry count above depth")
	`DEQ_ASSERT(a_count_step, clk, arst_n, (count_q != $past(count_q)) |-> ((count_q == $past(count_q) + 1'b1) || (count_q + 1'b1 == $past(count_q))), "entry count moved by more than one")
	`DEQ_ASSERT_NEVER(a_rw_same_slot, clk, arst_n, wr_en && rd_en && (wr_addr == rd_addr), "read and write of the same slot in one cycle")

endmodule

`default_nettype wire

/* tb/deq_result_checker.sv */
// Result checker for the double-ended queue: watches both channels, predicts each response
// item and compares it field by field.
// Depends on deq_pkg and the deq_in_if / deq_out_if interfaces.
`timescale 1ns / 1ps

module deq_result_checker #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = deq_pkg::VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	deq_in_if    req,
	deq_out_if   rsp,
	output int   failures,
	output int   pending
);
	import deq_pkg::*;

	localparam int COUNT_BITS = $clog2(DEPTH + 1);

	typedef struct {
		logic signed [VALUE_BITS-1:0] popped_value;
		status_t                      status;
		logic [COUNT_BITS-1:0]        entry_count;
	} deq_answer_t;

	// Front of the queue is index 0.
	logic signed [VALUE_BITS-1:0] held[$];
	deq_answer_t                  answers_due[$];
	deq_answer_t                  oldest;
	int                           mismatch_count = 0;
	int                           due_count = 0;

	assign failures = mismatch_count;
	assign pending  = due_count;

	function automatic deq_answer_t apply_request(input logic [OP_BITS-1:0] op,
		input logic signed [VALUE_BITS-1:0] v);
		deq_answer_t a;
		int          hit;
		a.popped_value = '0;
		a.status       = ST_OK;
		hit            = -1;
		case (op)
			OP_PUSH_BACK: begin
				if (held.size() >= DEPTH) a.status = ST_FULL;
				else held.push_back(v);
			end
			OP_PUSH_FRONT: begin
				if (held.size() >= DEPTH) a.status = ST_FULL;
				else held.push_front(v);
			end
			OP_POP_BACK: begin
				if (held.size() == 0) a.status = ST_EMPTY;
				else a.popped_value = held.pop_back();
			end
			OP_POP_FRONT: begin
				if (held.size() == 0) a.status = ST_EMPTY;
				else a.popped_value = held.pop_front();
			end
			OP_REMOVE: begin
				// take out the first match counted from the front
				for (int k = 0; k < held.size(); k++) begin
					if (held[k] == v) begin
						hit = k;
						break;
					end
				end
				if (hit < 0) a.status = ST_NOT_FOUND;
				else held.delete(hit);
			end
			default: ;
		endcase
		a.entry_count = COUNT_BITS'(held.size());
		return a;
	endfunction

	task automatic check_field(input string field, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (got !== want) begin
			mismatch_count++;
			$error("%s: expected %0d, got %0d", field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held.delete();
			answers_due.delete();
			due_count = 0;
		end else begin
			// predict first so an answer in the same cycle still finds its expectation
			if (req.valid && req.ready)
				answers_due.push_back(apply_request(req.operation, req.value));
			if (rsp.valid && rsp.ready) begin
				if (answers_due.size() == 0) begin
					mismatch_count++;
					$error("unexpected response item: popped_value %0d status %0d entry_count %0d",
						rsp.popped_value, rsp.status, rsp.entry_count);
				end else begin
					oldest = answers_due.pop_front();
					check_field("popped_value", oldest.popped_value, rsp.popped_value);
					check_field("status", oldest.status, rsp.status);
					check_field("entry_count", oldest.entry_count, rsp.entry_count);
				end
			end
			due_count = answers_due.size();
		end
	end

endmodule

/* tb/double_ended_queue_tb.sv */
// Top of the double-ended queue testbench: clock, reset, request stimulus and response stalls.
// Depends on deq_pkg, deq_if.sv, double_ended_queue and deq_result_checker.
`timescale 1ns / 1ps

module double_ended_queue_tb;
	import deq_pkg::*;

	localparam int                 DEPTH          = DEPTH_DEF;
	// codes past the last operation, which the block must ignore
	localparam logic [OP_BITS-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_BITS-1:0] OP_SPARE_LAST  = 3'd7;
	// idle time past the last response, for stray responses to show up
	localparam int                 SETTLE_CYCLES  = 20;
	localparam int                 RING_SIZE      = 16;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Percent of cycles in which each side holds off.
	int send_idle_pct = 15;
	int take_idle_pct = 49;

	int failures;
	int pending;

	// Recently pushed values, so that removes often hit something held.
	logic signed [VALUE_BITS_DEF-1:0] recent_pushes[RING_SIZE];
	int                               ring_pos = 0;

	always #6 clk = ~clk;

	deq_in_if  req_ch ();
	deq_out_if rsp_ch ();

	double_ended_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	deq_result_checker result_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.failures (failures),
		.pending  (pending)
	);

	// Stall the response side at random; change only at the falling edge.
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);
	end

	// Half the values from a small pool so that duplicates and matches are common,
	// the other half full-width random so every bit toggles.
	function automatic logic signed [VALUE_BITS_DEF-1:0] draw_value();
		case ($urandom_range(9))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2, 3, 4: return $signed(32'($urandom_range(6))) - 3;
			default: return $urandom();
		endcase
	endfunction

	// Offer one item, with random idle cycles in front, and hold it until accepted.
	// Entered and left at a falling edge.
	task automatic send_item(input logic [OP_BITS-1:0] op,
		input logic signed [VALUE_BITS_DEF-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.value     <= v;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
			recent_pushes[ring_pos] = v;
			ring_pos = (ring_pos + 1) % RING_SIZE;
		end
		@(negedge clk);
	endtask

	// One item of the mixed traffic: every operation, the spare codes now and then.
	task automatic send_mixed_item();
		logic [OP_BITS-1:0]           op;
		logic signed [VALUE_BITS_DEF-1:0] v;
		int                           r;
		r = $urandom_range(99);
		if (r < 25)      op = OP_PUSH_BACK;
		else if (r < 45) op = OP_PUSH_FRONT;
		else if (r < 60) op = OP_POP_BACK;
		else if (r < 75) op = OP_POP_FRONT;
		else if (r < 95) op = OP_REMOVE;
		else             op = OP_BITS'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
		if (op == OP_REMOVE && $urandom_range(99) < 60)
			v = recent_pushes[$urandom_range(RING_SIZE - 1)];
		else
			v = draw_value();
		send_item(op, v);
	endtask

	// Drop valid and hold off until every response has come back.
	task automatic hold_until_drained();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	initial begin
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_PUSH_BACK;
		req_ch.value     = '0;
		rsp_ch.ready     = 1'b0;
		foreach (recent_pushes[i]) recent_pushes[i] = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: every failure on an empty queue, then the spare codes.
		send_item(OP_POP_BACK, 32'sd0);
		send_item(OP_POP_FRONT, -32'sd1);
		send_item(OP_REMOVE, 32'sd0);
		for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
			send_item(OP_BITS'(c), 32'sh8000_0000);

		// Build [-1, min, max, 0, 1] from both ends with the extreme values.
		send_item(OP_PUSH_BACK, 32'sh7fff_ffff);
		send_item(OP_PUSH_FRONT, 32'sh8000_0000);
		send_item(OP_PUSH_BACK, 32'sd0);
		send_item(OP_PUSH_FRONT, -32'sd1);
		send_item(OP_PUSH_BACK, 32'sd1);

		// Remove: no match, a middle entry, the front entry, the back entry.
		send_item(OP_REMOVE, 32'sd5);
		send_item(OP_REMOVE, 32'sd0);
		send_item(OP_REMOVE, -32'sd1);
		send_item(OP_REMOVE, 32'sd1);

		// Duplicate value: only the first from the front goes.
		send_item(OP_PUSH_BACK, 32'sh8000_0000);
		send_item(OP_REMOVE, 32'sh8000_0000);

		// Spare code on a non-empty queue, then pop both ends down to empty and once past it.
		send_item(OP_SPARE_FIRST, 32'sh7fff_ffff);
		send_item(OP_POP_FRONT, 32'sd0);
		send_item(OP_POP_BACK, 32'sd0);
		send_item(OP_POP_BACK, 32'sd0);

		// Mixed traffic with a full drain in the middle.
		repeat (60) send_mixed_item();
		hold_until_drained();
		repeat (60) send_mixed_item();

		// Swap the stall pattern: sender idles more, receiver less.
		send_idle_pct = 49;
		take_idle_pct = 15;

		// Enough pushes to fill the queue from any level and overflow a few times.
		repeat (DEPTH + 6) begin
			send_item($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, draw_value());
		end
		hold_until_drained();

		// Mixed traffic near the top: long removes, pushes against the limit.
		repeat (50) send_mixed_item();

		// No stalls from here on.
		send_idle_pct = 0;
		take_idle_pct = 0;

		// Pop everything from random ends, then underflow a few times.
		repeat (DEPTH + 6) begin
			send_item($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, draw_value());
		end
		repeat (60) send_mixed_item();

		// Wait for the last responses, then stay idle so that stray responses can show up.
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog: far past the slowest correct run, removes at full depth included.
	initial begin
		#(10_000_000);
		$display("tb: failure");
		$finish;
	end

endmodule
